[sv/scafs_pkg.sv]
// ----------------------------------------------------------------------------
// scafs_pkg
// Shared types, codes and helpers of the FIFO-replacement cache tag model.
// ----------------------------------------------------------------------------
package scafs_pkg;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_FETCH  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OUT_HIT    = 2'd0,
        OUT_COLD   = 2'd1,
        OUT_EVICT  = 2'd2,
        OUT_IGNORE = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        REG_SET_BITS   = 2'd0,
        REG_BLOCK_BITS = 2'd1,
        REG_WAYS       = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [5:0] block_bits;
        logic [3:0] ways;
    } cfg_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + 32'd1;
    endfunction

endpackage

[sv/scafs_ram.sv]
// ----------------------------------------------------------------------------
// scafs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module scafs_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [2**ADDR_W];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/scafs_front.sv]
// ----------------------------------------------------------------------------
// scafs_front
// Access decode: split the address into set index and tag, push the beat.
// ----------------------------------------------------------------------------
module scafs_front #(
    parameter int MAX_SET_BITS = 6,
    parameter int SET_W        = 6
) (
    input  scafs_pkg::cfg_t    cfg,
    input  logic               start,
    input  logic               q_full,
    input  logic [1:0]         action,
    input  logic [63:0]        address,
    output logic               push,
    output logic [SET_W+65:0]  push_data
);
    import scafs_pkg::*;

    logic [2:0]       sb;
    logic [63:0]      blk_shift;
    logic [6:0]       tag_shift;
    logic [63:0]      tag;
    logic [SET_W-1:0] set_idx;

    always_comb
    begin
        sb        = (int'(cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg.set_bits;
        blk_shift = address >> cfg.block_bits;
        for (int i = 0; i < SET_W; i++)
        begin
            set_idx[i] = blk_shift[i] & (i < int'(sb));
        end
        tag_shift = 7'(sb) + 7'(cfg.block_bits);
        tag       = tag_shift[6] ? 64'd0 : (address >> tag_shift[5:0]);
    end

    assign push      = start & ~q_full;
    assign push_data = {action, set_idx, tag};

endmodule

[sv/scafs_queue.sv]
// ----------------------------------------------------------------------------
// scafs_queue
// Two-entry queue between access decode and the lookup unit.
// ----------------------------------------------------------------------------
module scafs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

[sv/scafs_back.sv]
// ----------------------------------------------------------------------------
// scafs_back
// Lookup unit: read the set's tags and fill state, compare, fill or evict.
// ----------------------------------------------------------------------------
module scafs_back #(
    parameter int MAX_WAYS = 8,
    parameter int SET_W    = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  scafs_pkg::cfg_t    cfg,
    input  logic               q_empty,
    input  logic [SET_W+65:0]  q_head,
    output logic               q_pop,
    output logic               done,
    output logic [1:0]         outcome,
    output logic               extra_hit,
    output logic [31:0]        hit_count,
    output logic [31:0]        miss_count,
    output logic [31:0]        evict_count
);
    import scafs_pkg::*;

    localparam int NUM_SETS = 1 << SET_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILL_W   = $clog2(MAX_WAYS + 1);
    localparam int META_W   = FILL_W + WAY_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    action_t            cur_action_reg;
    logic [SET_W-1:0]   cur_set_reg;
    logic [63:0]        cur_tag_reg;
    logic [NUM_SETS-1:0] set_valid_reg, set_valid_next;
    logic [31:0]        hits_reg, hits_next;
    logic [31:0]        misses_reg, misses_next;
    logic [31:0]        evicts_reg, evicts_next;
    logic               done_reg, done_next;
    outcome_t           outcome_reg, outcome_next;
    logic               extra_reg, extra_next;

    action_t            head_action;
    logic [SET_W-1:0]   head_set;
    logic [63:0]        head_tag;
    logic [63:0]        tag_rd [MAX_WAYS];
    logic [MAX_WAYS-1:0] tag_wr;
    logic [META_W-1:0]  meta_rd, meta_wd;
    logic               meta_wr;
    logic [FILL_W-1:0]  we_cnt, fill, fill_next, vict_ext;
    logic [WAY_W-1:0]   oldest, oldest_next, victim;
    logic               hit;
    logic [31:0]        h1;

    assign head_action = action_t'(q_head[SET_W+65:SET_W+64]);
    assign head_set    = q_head[SET_W+63:64];
    assign head_tag    = q_head[63:0];

    for (genvar w = 0; w < MAX_WAYS; w++)
    begin : g_way
        scafs_ram #(.WIDTH(64), .ADDR_W(SET_W)) u_tag_ram (
            .clk     (clk),
            .wr_en   (tag_wr[w]),
            .wr_addr (cur_set_reg),
            .wr_data (cur_tag_reg),
            .rd_addr (head_set),
            .rd_data (tag_rd[w])
        );
    end

    scafs_ram #(.WIDTH(META_W), .ADDR_W(SET_W)) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_wr),
        .wr_addr (cur_set_reg),
        .wr_data (meta_wd),
        .rd_addr (head_set),
        .rd_data (meta_rd)
    );

    always_comb
    begin
        if (cfg.ways == 4'd0)
            we_cnt = FILL_W'(1);
        else if (int'(cfg.ways) > MAX_WAYS)
            we_cnt = FILL_W'(MAX_WAYS);
        else
            we_cnt = FILL_W'(cfg.ways);

        fill   = set_valid_reg[cur_set_reg] ? meta_rd[META_W-1:WAY_W] : '0;
        oldest = set_valid_reg[cur_set_reg] ? meta_rd[WAY_W-1:0] : '0;

        hit = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if ((FILL_W'(w) < we_cnt) && (FILL_W'(w) < fill) && (tag_rd[w] == cur_tag_reg))
                hit = 1'b1;
        end

        if (fill < we_cnt)
        begin
            victim      = WAY_W'(fill);
            fill_next   = fill + FILL_W'(1);
            oldest_next = oldest;
        end
        else
        begin
            victim      = (FILL_W'(oldest) >= we_cnt) ? '0 : oldest;
            fill_next   = fill;
            vict_ext    = FILL_W'(victim) + FILL_W'(1);
            oldest_next = (vict_ext >= we_cnt) ? '0 : WAY_W'(vict_ext);
        end
        vict_ext = FILL_W'(victim) + FILL_W'(1);

        meta_wd = {fill_next, oldest_next};
        meta_wr = (state_reg == ST_LOOK) && !hit;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            tag_wr[w] = meta_wr && (victim == WAY_W'(w));
        end

        state_next     = state_reg;
        set_valid_next = set_valid_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        evicts_next    = evicts_reg;
        done_next      = 1'b0;
        outcome_next   = outcome_reg;
        extra_next     = 1'b0;
        q_pop          = 1'b0;
        h1             = hits_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (head_action == ACT_FETCH)
                    begin
                        done_next    = 1'b1;
                        outcome_next = OUT_IGNORE;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (hit)
                begin
                    outcome_next = OUT_HIT;
                    h1           = sat_inc(hits_reg);
                end
                else
                begin
                    set_valid_next[cur_set_reg] = 1'b1;
                    misses_next  = sat_inc(misses_reg);
                    if (fill < we_cnt)
                    begin
                        outcome_next = OUT_COLD;
                    end
                    else
                    begin
                        outcome_next = OUT_EVICT;
                        evicts_next  = sat_inc(evicts_reg);
                    end
                end
                if (cur_action_reg == ACT_MODIFY)
                begin
                    extra_next = 1'b1;
                    hits_next  = sat_inc(h1);
                end
                else
                begin
                    hits_next = h1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            set_valid_reg <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            done_reg      <= 1'b0;
            outcome_reg   <= OUT_HIT;
            extra_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            set_valid_reg <= set_valid_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evicts_reg    <= evicts_next;
            done_reg      <= done_next;
            outcome_reg   <= outcome_next;
            extra_reg     <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_action_reg <= head_action;
            cur_set_reg    <= head_set;
            cur_tag_reg    <= head_tag;
        end
    end

    assign done        = done_reg;
    assign outcome     = outcome_reg;
    assign extra_hit   = extra_reg;
    assign hit_count   = hits_reg;
    assign miss_count  = misses_reg;
    assign evict_count = evicts_reg;

    a_look_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK |=> state_reg == ST_IDLE)
        else $error("lookup held for more than one cycle");

    a_ignore_stable: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && outcome_reg == OUT_IGNORE |-> !extra_reg && $stable(hits_reg)
            && $stable(misses_reg) && $stable(evicts_reg))
        else $error("ignored beat changed the counters");

    a_no_pop_in_look: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK |-> !q_pop)
        else $error("queue popped during lookup");

    a_evict_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && outcome_reg == OUT_EVICT |-> evicts_reg != $past(evicts_reg)
            || evicts_reg == CNT_MAX)
        else $error("eviction not counted");

endmodule

[sv/set_assoc_cache_fifo_sim.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_sim
// Set-associative cache tag model with first-in first-out replacement.
// ----------------------------------------------------------------------------
// An access is taken on a cycle with start high and busy low; busy rises only
// when the two-entry queue in front of the lookup unit is full. A load, store
// or modify passes through the idle and lookup states: in the idle state it is
// popped and every way's tag and the set's fill state are read from RAM; in the
// lookup state the tags are compared, on a miss the victim tag and fill state
// are written, and the counters are updated. An instruction fetch is popped and
// retired in the idle state. No access is popped while one is in the lookup
// state. done is registered; it stays high for one cycle and cannot be held off.
// The per-set valid bits clear at reset, so no clearing pass is needed.
module set_assoc_cache_fifo_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [63:0] address,
    output logic        done,
    output logic [1:0]  outcome,
    output logic        extra_hit,
    output logic [31:0] hit_count,
    output logic [31:0] miss_count,
    output logic [31:0] evict_count
);
    import scafs_pkg::*;

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ITEM_W = SET_W + 66;

    cfg_t              cfg_reg, cfg_next;
    reg_index_t        reg_idx;
    logic              wr_beat;
    logic              push, pop, q_full, q_empty;
    logic [ITEM_W-1:0] push_data, q_head;

    assign reg_idx = reg_index_t'(paddr[3:2]);
    assign wr_beat = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_idx)
            REG_SET_BITS:
            begin
                prdata = 32'(cfg_reg.set_bits);
                if (wr_beat)
                    cfg_next.set_bits = pwdata[2:0];
            end
            REG_BLOCK_BITS:
            begin
                prdata = 32'(cfg_reg.block_bits);
                if (wr_beat)
                    cfg_next.block_bits = pwdata[5:0];
            end
            REG_WAYS:
            begin
                prdata = 32'(cfg_reg.ways);
                if (wr_beat)
                    cfg_next.ways = pwdata[3:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{set_bits: 3'd0, block_bits: 6'd0, ways: 4'd1};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign busy = q_full;

    scafs_front #(.MAX_SET_BITS(MAX_SET_BITS), .SET_W(SET_W)) u_front (
        .cfg       (cfg_reg),
        .start     (start),
        .q_full    (q_full),
        .action    (action),
        .address   (address),
        .push      (push),
        .push_data (push_data)
    );

    scafs_queue #(.WIDTH(ITEM_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    scafs_back #(.MAX_WAYS(MAX_WAYS), .SET_W(SET_W)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (pop),
        .done        (done),
        .outcome     (outcome),
        .extra_hit   (extra_hit),
        .hit_count   (hit_count),
        .miss_count  (miss_count),
        .evict_count (evict_count)
    );

endmodule

[verif/set_assoc_cache_fifo_sim_tb.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_sim_tb
// Drives memory accesses into the FIFO-replacement cache tag model under
// several geometries, predicts each outcome and counter set in a behavioural
// cache model, and checks every result beat against it in order.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_sim_tb;
    import scafs_pkg::*;

    localparam int NSETS = 64;
    localparam int NWAYS = 8;
    localparam longint LIMIT = 400000;

    typedef struct {
        outcome_t    outc;
        logic        extra;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } access_res_t;

    class cache_board;
        logic [2:0]  set_bits;
        logic [5:0]  block_bits;
        logic [3:0]  ways;
        logic        valid [NSETS*NWAYS];
        logic [63:0] tags  [NSETS*NWAYS];
        int          fill  [NSETS];
        int          oldest [NSETS];
        logic [31:0] hits, misses, evicts;
        access_res_t pending [$];
        int          errors;

        function new();
            set_bits = 0;
            block_bits = 0;
            ways = 1;
            foreach (valid[i]) valid[i] = 0;
            foreach (fill[i])
            begin
                fill[i] = 0;
                oldest[i] = 0;
            end
            hits = 0;
            misses = 0;
            evicts = 0;
            errors = 0;
        endfunction

        function automatic logic [31:0] bump(logic [31:0] c);
            return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
        endfunction

        function automatic logic [63:0] shr(logic [63:0] v, int n);
            return (n >= 64) ? 64'd0 : (v >> n);
        endfunction

        function void note_access(action_t act, logic [63:0] addr);
            access_res_t r;
            int sb, we, s, base, w;
            logic [63:0] tag;
            bit hit;
            r.extra = 0;
            if (act == ACT_FETCH)
            begin
                r.outc = OUT_IGNORE;
            end
            else
            begin
                sb = (set_bits > 6) ? 6 : set_bits;
                we = (ways == 0) ? 1 : ((ways > NWAYS) ? NWAYS : ways);
                s = int'(shr(addr, block_bits) & ((64'd1 << sb) - 1));
                tag = shr(addr, sb + block_bits);
                base = s * NWAYS;
                hit = 0;
                for (w = 0; w < we; w++)
                    if (!hit && valid[base+w] && tags[base+w] == tag) hit = 1;
                if (hit)
                begin
                    r.outc = OUT_HIT;
                    hits = bump(hits);
                end
                else if (fill[s] < we)
                begin
                    w = fill[s];
                    valid[base+w] = 1;
                    tags[base+w] = tag;
                    fill[s] = w + 1;
                    r.outc = OUT_COLD;
                    misses = bump(misses);
                end
                else
                begin
                    w = oldest[s];
                    if (w >= we) w = 0;
                    valid[base+w] = 1;
                    tags[base+w] = tag;
                    oldest[s] = (w + 1 >= we) ? 0 : w + 1;
                    r.outc = OUT_EVICT;
                    misses = bump(misses);
                    evicts = bump(evicts);
                end
                if (act == ACT_MODIFY)
                begin
                    r.extra = 1;
                    hits = bump(hits);
                end
            end
            r.hits = hits;
            r.misses = misses;
            r.evicts = evicts;
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] o, logic x, logic [31:0] h,
                                   logic [31:0] m, logic [31:0] e);
            access_res_t r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat outcome %0d", $time, o);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (o !== r.outc)
            begin
                $display("%0t: outcome exp %0d got %0d", $time, r.outc, o);
                errors++;
            end
            if (x !== r.extra)
            begin
                $display("%0t: extra_hit exp %0d got %0d", $time, r.extra, x);
                errors++;
            end
            if (h !== r.hits)
            begin
                $display("%0t: hit_count exp %0d got %0d", $time, r.hits, h);
                errors++;
            end
            if (m !== r.misses)
            begin
                $display("%0t: miss_count exp %0d got %0d", $time, r.misses, m);
                errors++;
            end
            if (e !== r.evicts)
            begin
                $display("%0t: evict_count exp %0d got %0d", $time, r.evicts, e);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 0;
    logic        busy;
    logic [1:0]  action = 0;
    logic [63:0] address = 0;
    logic        done;
    logic [1:0]  outcome;
    logic        extra_hit;
    logic [31:0] hit_count, miss_count, evict_count;

    cache_board board = new();
    longint cycles = 0;
    logic [63:0] tag_pool [8];

    set_assoc_cache_fifo_sim dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (done) board.check_result(outcome, extra_hit, hit_count, miss_count,
                                     evict_count);
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = 4'(idx) << 2;
        pwdata = val;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        case (idx)
            REG_SET_BITS:   board.set_bits = val[2:0];
            REG_BLOCK_BITS: board.block_bits = val[5:0];
            default:        board.ways = val[3:0];
        endcase
    endtask

    task automatic configure(int sb, int bb, int wy);
        wait (board.pending.size() == 0);
        repeat (6) @(negedge clk);
        write_reg(REG_SET_BITS, sb);
        write_reg(REG_BLOCK_BITS, bb);
        write_reg(REG_WAYS, wy);
    endtask

    // wait a random gap if gaps is set, then hold start until the beat is taken and drop it
    task automatic send_access(action_t act, logic [63:0] addr, bit gaps);
        int gap;
        gap = gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0) : 0;
        if (gap > 0)
        begin
            start = 0;
            repeat (gap) @(negedge clk);
        end
        start = 1;
        action = act;
        address = addr;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_access(act, addr);
        @(negedge clk);
        start = 0;
    endtask

    function automatic logic [63:0] pick_addr(int sb, int bb);
        logic [63:0] a;
        int s;
        s = $urandom_range(0, 7);
        a = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 8)
        begin
            // reuse a small tag pool so sets fill, hit and evict
            a = (tag_pool[$urandom_range(0, 7)] << 6) | 64'(s);
            a = (bb >= 64) ? a : ((a << bb) | (64'({$urandom, $urandom}) &
                 ((64'd1 << bb) - 1)));
        end
        return a;
    endfunction

    initial
    begin
        int sb, bb, wy, phase, i;
        action_t act;
        foreach (tag_pool[k]) tag_pool[k] = 64'(k);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset geometry: one set, one way, byte blocks
        send_access(ACT_LOAD, 64'd0, 0);
        send_access(ACT_LOAD, 64'd0, 0);
        send_access(ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_access(ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_access(ACT_FETCH, 64'h1234, 0);
        send_access(ACT_MODIFY, 64'h5, 0);
        configure(7, 32, 0);
        send_access(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_access(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_access(ACT_LOAD, 64'h0000_0001_0000_0000, 0);
        configure(6, 63, 15);
        send_access(ACT_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        send_access(ACT_STORE, 64'h5555_5555_5555_5555, 0);
        send_access(ACT_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        configure(2, 4, 2);
        for (i = 0; i < 6; i++) send_access(ACT_LOAD, 64'(i) << 6, 0);
        send_access(ACT_LOAD, 64'd0, 0);
        configure(2, 4, 1);
        send_access(ACT_LOAD, 64'd0, 0);

        for (phase = 0; phase < 8; phase++)
        begin
            sb = (phase == 0) ? 0 : (phase == 1) ? 6 : $urandom_range(0, 7);
            bb = (phase == 2) ? 0 : (phase == 3) ? 63 : $urandom_range(0, 12);
            wy = (phase == 4) ? 8 : (phase == 5) ? 1 : $urandom_range(0, 15);
            configure(sb, bb, wy);
            for (i = 0; i < 90; i++)
            begin
                act = action_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
                send_access(act, pick_addr(sb > 6 ? 6 : sb, bb), i > 15);
            end
        end

        wait (board.pending.size() == 0);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[files.f]
sv/scafs_pkg.sv
sv/scafs_ram.sv
sv/scafs_front.sv
sv/scafs_queue.sv
sv/scafs_back.sv
sv/set_assoc_cache_fifo_sim.sv
verif/set_assoc_cache_fifo_sim_tb.sv
